// File: design/est_pkg.sv
// Shared types and constants for the EMG segment effort tracker.
// No dependencies; imported by est_div, emg_segment_effort_tracker and est_chk.
package est_pkg;

	localparam int RMS_W     = 16;
	localparam int STAMP_W   = 32;
	localparam int CNT_W     = 12;
	localparam int SUM_W     = 28;
	localparam int RAW_W     = 20;
	localparam int EFF_W     = 16;
	localparam int MVC_W     = 16;
	localparam int TOTAL_W   = EFF_W + 2;

	localparam int NUM_W     = SUM_W + 14;        // sum * 16384
	localparam int DEN_W     = SUM_W;             // mvc * count
	localparam int DCNT_W    = $clog2(NUM_W);

	localparam logic [CNT_W-1:0] MAX_SEG_LEN = CNT_W'(4095);
	localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
	localparam logic [RAW_W-1:0] RAW_MAX     = {RAW_W{1'b1}};
	localparam logic [EFF_W-1:0] EFF_MAX     = {EFF_W{1'b1}};
	localparam logic [MVC_W-1:0] MVC_RESET   = {MVC_W{1'b1}};
	localparam int HISTORY_DEPTH = 3;

	// divide by HISTORY_DEPTH as multiply by ceil(2^19 / 3) and shift; exact for totals below 2^19
	localparam int AVG_SHIFT = 19;
	localparam logic [TOTAL_W-1:0] AVG_RECIP = TOTAL_W'(174763);

	localparam int IN_DATA_W  = 56;   // seg_active, rms, timestamp (49 bits used)
	localparam int OUT_DATA_W = 136;  // raw, effort, three stamps (132 bits used)

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_MVC = PADDR_W'(0);

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_resp_t;

endpackage

// File: design/est_div.sv
// Restoring divider, one quotient bit per cycle, shared by the raw and normalized effort divisions.
// Depends on est_pkg (div_req_t, div_resp_t, widths).
module est_div import est_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_resp_t resp
);

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_sub;
	logic           ge;

	assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quo_q shifts the dividend out at the top and the quotient in at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign resp.done     = done_q;
	assign resp.quotient = quo_q;

endmodule

// File: design/emg_segment_effort_tracker.sv
// Top level of the EMG segment effort tracker: stream ports, APB register, sequencer.
// Depends on est_pkg and est_div.
//
//  port group   dir  transaction carries
//  s_*          in   kind (tuser), seg_active, rms, timestamp
//  m_*          out  seg_start/seg_end (tuser), raw_effort, effort, stamps
//  apb (p*)     in   mvc register at byte address 0
//
// An item that does not end a segment moves the sequencer to its final step, which loads
// the output register once it is free; the next transaction is taken after that step.
// An item that ends a segment is processed by two passes through the shared 42-bit
// restoring divider (raw effort, normalized effort), one step for the three-segment
// mean by reciprocal multiply, and one to load the output register. s_tready is high
// only while the sequencer is idle; a new item is taken while a result still waits in
// the output register, and the sequencer stalls in its last step until that register
// is free.
// arst_n asynchronously clears the sequencer, segment state, divider control and output valid; mvc comes up as 65535.
module emg_segment_effort_tracker import est_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] seg_active, [16:1] rms, [48:17] timestamp
	input  logic                  s_tuser,   // [0] kind
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [19:0] raw_effort, [35:20] effort,
	                                         // [67:36] start_time, [99:68] stop_time,
	                                         // [131:100] peak_time
	output logic [1:0]            m_tuser,   // [0] seg_start, [1] seg_end
	// APB register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RAW_GO   = 3'd1;
	localparam logic [2:0] ST_RAW_WAIT = 3'd2;
	localparam logic [2:0] ST_EFF_GO   = 3'd3;
	localparam logic [2:0] ST_EFF_WAIT = 3'd4;
	localparam logic [2:0] ST_AVG      = 3'd5;
	localparam logic [2:0] ST_FIN      = 3'd6;

	logic [2:0] state_q;

	logic [MVC_W-1:0]   mvc_q;
	logic               running_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [RMS_W-1:0]   peak_rms_q;
	logic [STAMP_W-1:0] peak_stamp_q;
	logic [STAMP_W-1:0] start_stamp_q;
	logic [STAMP_W-1:0] stop_stamp_q;
	logic [EFF_W-1:0]   hist_q [HISTORY_DEPTH];

	logic               res_start_q;
	logic               res_end_q;
	logic [RAW_W-1:0]   res_raw_q;
	logic [EFF_W-1:0]   res_eff_q;
	logic [DEN_W-1:0]   prod_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	div_req_t  div_req;
	div_resp_t div_resp;

	// input fields
	logic               in_kind;
	logic               in_active;
	logic [RMS_W-1:0]   in_rms;
	logic [STAMP_W-1:0] in_stamp;
	logic               in_acc;
	logic               cfg_wr;
	logic               out_free;

	assign in_kind   = s_tuser;
	assign in_active = s_tdata[0];
	assign in_rms    = s_tdata[16:1];
	assign in_stamp  = s_tdata[48:17];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == ADDR_MVC) ? {{(32-MVC_W){1'b0}}, mvc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvc_q <= MVC_RESET;
		end else if (cfg_wr && paddr == ADDR_MVC) begin
			mvc_q <= pwdata[MVC_W-1:0];
		end
	end

	// accumulator next values
	logic [SUM_W:0]       sum_add;
	logic [SUM_W-1:0]     sum_next;
	logic [CNT_W-1:0]     count_next;
	logic [MVC_W-1:0]     mvc_eff;
	logic [CNT_W-1:0]     cnt_eff;
	logic [TOTAL_W-1:0]   hist_total;
	logic [2*TOTAL_W-1:0] avg_prod;

	assign sum_add    = {1'b0, sum_q} + {{(SUM_W+1-RMS_W){1'b0}}, in_rms};
	assign sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
	assign count_next = (count_q < MAX_SEG_LEN) ? count_q + 1'b1 : count_q;
	assign mvc_eff    = (mvc_q == '0) ? MVC_W'(1) : mvc_q;
	assign cnt_eff    = (count_q == '0) ? CNT_W'(1) : count_q;
	assign hist_total = TOTAL_W'(hist_q[0]) + TOTAL_W'(hist_q[1]) + TOTAL_W'(hist_q[2]);
	assign avg_prod   = (2*TOTAL_W)'(hist_total) * (2*TOTAL_W)'(AVG_RECIP);

	always_ff @(posedge clk) begin
		prod_q <= DEN_W'(mvc_eff) * DEN_W'(cnt_eff);
	end

	// operand select for the shared divider
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_RAW_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = NUM_W'({sum_q, 4'b0});
				div_req.divisor  = DEN_W'(cnt_eff);
			end
			ST_EFF_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {sum_q, 14'b0};
				div_req.divisor  = prod_q;
			end
			default: ;
		endcase
	end

	est_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// sequencer and segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			running_q     <= 1'b0;
			count_q       <= '0;
			sum_q         <= '0;
			peak_rms_q    <= '0;
			peak_stamp_q  <= '0;
			start_stamp_q <= '0;
			stop_stamp_q  <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_FIN;
						if (in_kind == KIND_CLEAR) begin
							running_q  <= 1'b0;
							count_q    <= '0;
							sum_q      <= '0;
							peak_rms_q <= '0;
							for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
						end else if (!running_q) begin
							count_q    <= '0;
							sum_q      <= '0;
							peak_rms_q <= '0;
							if (in_active) begin
								peak_rms_q    <= in_rms;
								start_stamp_q <= in_stamp;
								running_q     <= 1'b1;
							end
						end else begin
							count_q <= count_next;
							sum_q   <= sum_next;
							if (in_rms > peak_rms_q) begin
								peak_rms_q   <= in_rms;
								peak_stamp_q <= in_stamp;
							end
							if (!in_active) begin
								running_q    <= 1'b0;
								stop_stamp_q <= in_stamp;
								state_q      <= ST_RAW_GO;
							end
						end
					end
				end
				ST_RAW_GO:   state_q <= ST_RAW_WAIT;
				ST_RAW_WAIT: if (div_resp.done) state_q <= ST_EFF_GO;
				ST_EFF_GO:   state_q <= ST_EFF_WAIT;
				ST_EFF_WAIT: begin
					if (div_resp.done) begin
						hist_q[0] <= hist_q[1];
						hist_q[1] <= hist_q[2];
						hist_q[2] <= (div_resp.quotient[NUM_W-1:EFF_W] != '0) ?
							EFF_MAX : div_resp.quotient[EFF_W-1:0];
						state_q   <= ST_AVG;
					end
				end
				ST_AVG:      state_q <= ST_FIN;
				ST_FIN:      if (out_free) state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	// pending result fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_start_q <= (in_kind == KIND_SAMPLE) && !running_q && in_active;
			res_end_q   <= (in_kind == KIND_SAMPLE) && running_q && !in_active;
			res_raw_q   <= '0;
			res_eff_q   <= '0;
		end
		if (state_q == ST_RAW_WAIT && div_resp.done) begin
			res_raw_q <= (div_resp.quotient[NUM_W-1:RAW_W] != '0) ?
				RAW_MAX : div_resp.quotient[RAW_W-1:0];
		end
		// history already holds the new effort here
		if (state_q == ST_AVG) begin
			res_eff_q <= avg_prod[AVG_SHIFT+EFF_W-1:AVG_SHIFT];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			m_tuser_q <= {res_end_q, res_start_q};
			m_tdata_q <= {4'b0, peak_stamp_q, stop_stamp_q, start_stamp_q,
				res_eff_q, res_raw_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: design/est_chk.sv
// Port-level checker for emg_segment_effort_tracker, bound to the top level.
// Depends on est_pkg for widths.
module est_chk import est_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in flight: never ready right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("segment start and end in one result");

	// effort fields are zero unless the segment ended
	a_effort_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[35:0] == 36'd0)
		else $error("effort reported without segment end");

endmodule

bind emg_segment_effort_tracker est_chk u_est_chk (.*);
